### design/hermite_elevation_profile_fit_unit_macros.svh
// Assertion helpers used by hefit_ctrl.
`ifndef HERMITE_ELEVATION_PROFILE_FIT_UNIT_MACROS_SVH
`define HERMITE_ELEVATION_PROFILE_FIT_UNIT_MACROS_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define HEFIT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define HEFIT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/hefit_pkg.sv
package hefit_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int MIN_SP_W      = 16;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;
    localparam logic [MIN_SP_W-1:0] MIN_SP_RESET = 16'd1;

    typedef struct packed {
        logic signed [31:0] station;
        logic signed [31:0] elevation;
        logic               last_point;
    } in_t;

    typedef struct packed {
        logic signed [31:0] segment_start;
        logic signed [31:0] coef_a;
        logic signed [47:0] coef_b;
        logic signed [47:0] coef_c;
        logic signed [47:0] coef_d;
        logic               status;
        logic               last_segment;
    } out_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SET_PRIOR,
        OP_SHIFT,
        OP_TAN,
        OP_SEG_LOAD,
        OP_MUL,
        OP_DIV_C,
        OP_DIV_D,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [1:0] {
        MUL_MH,
        MUL_QH,
        MUL_H2,
        MUL_H3
    } mul_sel_t;

    typedef enum logic [1:0] {
        EMIT_LONE,
        EMIT_ERR,
        EMIT_SEG
    } emit_kind_t;

    typedef struct packed {
        dp_op_t     op;
        logic       pair_older;    // operands start at the older point
        logic       tan_to_b;      // tangent lands in tb, else ta
        logic       m0_older_tan;  // m0 from stored older tangent, else ta
        logic       m1_from_b;     // m1 from tb, else ta
        logic       seg_last;
        mul_sel_t   mul_sel;
        emit_kind_t kind;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic too_close;
        logic in_last;
        logic out_free;
    } dp_sts_t;

endpackage

### design/hefit_mul.sv
// Signed x unsigned multiplier, one 8-bit digit of b per cycle.
module hefit_mul #(
    parameter int AW = 65,
    parameter int BW = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [AW-1:0]     a,
    input  logic        [BW-1:0]     b,
    output logic                     done,
    output logic signed [AW+BW-1:0]  prod
);
    localparam int PW    = AW + BW;
    localparam int DIG   = 8;
    localparam int ND    = (BW + DIG - 1) / DIG;
    localparam int CNT_W = (ND > 1) ? $clog2(ND) : 1;
    localparam int BSH_W = ND * DIG;

    logic                    busy_reg;
    logic                    done_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [PW-1:0]    a_sh_reg;
    logic [BSH_W-1:0]        b_sh_reg;
    logic signed [PW-1:0]    acc_reg;
    logic signed [PW-1:0]    part;

    assign part = a_sh_reg * $signed({1'b0, b_sh_reg[DIG-1:0]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ND - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_sh_reg <= {{BW{a[AW-1]}}, a};
            b_sh_reg <= BSH_W'(b);
            acc_reg  <= '0;
        end else if (busy_reg) begin
            acc_reg  <= acc_reg + part;
            a_sh_reg <= a_sh_reg <<< DIG;
            b_sh_reg <= b_sh_reg >> DIG;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

### design/hefit_div.sv
// Restoring divider, round half away from zero, saturated to 48 bits.
// One quotient bit per cycle; 50 bits cover the saturation range.
module hefit_div #(
    parameter int NW = 118,
    parameter int DW = 96
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic        [DW-1:0] den,
    output logic                 done,
    output logic signed [47:0]   quo
);
    localparam int QW    = 50;
    localparam int RW    = (NW + 2 > DW + 1 + QW) ? NW + 2 : DW + 1 + QW;
    localparam int CNT_W = $clog2(QW);

    typedef enum logic [1:0] {D_IDLE, D_ABS, D_PREP, D_ITER} div_state_t;

    div_state_t          state_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic signed [NW-1:0] num_reg;
    logic [DW-1:0]       den_reg;
    logic                neg_reg;
    logic [NW-1:0]       mag_reg;
    logic [RW-1:0]       r_reg;
    logic [RW-1:0]       dsh_reg;
    logic [QW-1:0]       q_reg;
    logic                ge;
    logic                pos_ovf;
    logic                neg_ovf;

    assign ge = r_reg >= dsh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE: if (start) state_reg <= D_ABS;
                D_ABS:  state_reg <= D_PREP;
                D_PREP: begin
                    state_reg <= D_ITER;
                    cnt_reg   <= CNT_W'(QW - 1);
                end
                D_ITER: begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= D_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (start && state_reg == D_IDLE) begin
            num_reg <= num;
            den_reg <= den;
        end
        if (state_reg == D_ABS) begin
            neg_reg <= num_reg[NW-1];
            mag_reg <= num_reg[NW-1] ? NW'(-num_reg) : NW'(num_reg);
        end
        if (state_reg == D_PREP) begin
            // (2|n| + d) / (2d) gives the rounded quotient
            r_reg   <= RW'({mag_reg, 1'b0}) + RW'(den_reg);
            dsh_reg <= RW'({den_reg, 1'b0}) << (QW - 1);
            q_reg   <= '0;
        end
        if (state_reg == D_ITER) begin
            r_reg   <= ge ? r_reg - dsh_reg : r_reg;
            q_reg   <= {q_reg[QW-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign pos_ovf = |q_reg[QW-1:47];
    assign neg_ovf = (|q_reg[QW-1:48]) || (q_reg[47] && (|q_reg[46:0]));

    always_comb begin
        if (neg_reg) begin
            quo = neg_ovf ? $signed({1'b1, 47'b0}) : -$signed(q_reg[47:0]);
        end else begin
            quo = pos_ovf ? $signed({1'b0, {47{1'b1}}}) : $signed(q_reg[47:0]);
        end
    end

    assign done = done_reg;

endmodule

### design/hefit_dp.sv
// Datapath: point history, segment operands, shared multiplier and divider,
// result register.
module hefit_dp #(
    parameter int FRAC_BITS = hefit_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_fire,
    input  hefit_pkg::in_t                    s_data,
    input  logic [hefit_pkg::MIN_SP_W-1:0]    min_spacing,
    input  hefit_pkg::dp_cmd_t                cmd,
    output hefit_pkg::dp_sts_t                sts,
    output logic                              m_valid,
    input  logic                              m_ready,
    output hefit_pkg::out_t                   m_data
);
    localparam int NUM_W = 86 + 2 * FRAC_BITS;
    localparam int DEN_W = 96;
    localparam int MUL_AW = 65;
    localparam int MUL_BW = 32;
    localparam int PROD_W = MUL_AW + MUL_BW;
    localparam int P_W   = 82;
    localparam int CORE_W = 85;

    typedef enum logic [1:0] {DST_TA, DST_TB, DST_C, DST_D} div_dst_t;

    hefit_pkg::in_t      in_reg;
    logic signed [31:0]  prior_s_reg, prior_z_reg, older_s_reg, older_z_reg;
    logic signed [47:0]  older_tan_reg, ta_reg, tb_reg;
    logic signed [31:0]  s0_reg, z0_reg;
    logic [31:0]         h_reg;
    logic signed [32:0]  dz_reg;
    logic signed [47:0]  m0_reg, m1_reg;
    logic                seg_last_reg;
    logic signed [P_W-1:0] p_reg, qh_reg;
    logic [63:0]         h2_reg;
    logic [95:0]         h3_reg;
    logic signed [47:0]  c_reg, d_reg;
    hefit_pkg::mul_sel_t mul_dest_reg;
    div_dst_t            div_dest_reg;
    hefit_pkg::out_t     out_reg;
    logic                out_valid_reg;

    logic signed [32:0]  step_s;
    logic signed [31:0]  pair_s, pair_z, seg_s0, seg_z0, seg_s1, seg_z1;
    logic [31:0]         tan_ds;
    logic signed [32:0]  tan_dz;
    logic signed [48:0]  q_diff;
    logic [CORE_W-1:0]   c_core, d_core;
    logic signed [MUL_AW-1:0] mul_a;
    logic                mul_start, mul_done;
    logic signed [PROD_W-1:0] mul_prod;
    logic                div_start, div_done;
    logic signed [NUM_W-1:0] div_num;
    logic [DEN_W-1:0]    div_den;
    logic signed [47:0]  div_quo;

    assign step_s = {in_reg.station[31], in_reg.station} - {prior_s_reg[31], prior_s_reg};

    assign pair_s = cmd.pair_older ? older_s_reg : prior_s_reg;
    assign pair_z = cmd.pair_older ? older_z_reg : prior_z_reg;
    assign tan_ds = 32'(in_reg.station - pair_s);
    assign tan_dz = {in_reg.elevation[31], in_reg.elevation} - {pair_z[31], pair_z};

    assign seg_s0 = cmd.pair_older ? older_s_reg : prior_s_reg;
    assign seg_z0 = cmd.pair_older ? older_z_reg : prior_z_reg;
    assign seg_s1 = cmd.pair_older ? prior_s_reg : in_reg.station;
    assign seg_z1 = cmd.pair_older ? prior_z_reg : in_reg.elevation;

    assign q_diff = {m1_reg[47], m1_reg} - {m0_reg[47], m0_reg};

    // 3P - QH and QH - 2P
    assign c_core = {{3{p_reg[P_W-1]}}, p_reg} + {{2{p_reg[P_W-1]}}, p_reg, 1'b0}
                  - {{3{qh_reg[P_W-1]}}, qh_reg};
    assign d_core = {{3{qh_reg[P_W-1]}}, qh_reg} - {{2{p_reg[P_W-1]}}, p_reg, 1'b0};

    always_comb begin
        unique case (cmd.mul_sel)
            hefit_pkg::MUL_MH: mul_a = {{(MUL_AW-48){m0_reg[47]}}, m0_reg};
            hefit_pkg::MUL_QH: mul_a = {{(MUL_AW-49){q_diff[48]}}, q_diff};
            hefit_pkg::MUL_H2: mul_a = {{(MUL_AW-32){1'b0}}, h_reg};
            hefit_pkg::MUL_H3: mul_a = {1'b0, h2_reg};
            default:           mul_a = '0;
        endcase
    end

    assign mul_start = (cmd.op == hefit_pkg::OP_MUL);
    assign div_start = (cmd.op == hefit_pkg::OP_TAN) || (cmd.op == hefit_pkg::OP_DIV_C)
                    || (cmd.op == hefit_pkg::OP_DIV_D);

    always_comb begin
        priority if (cmd.op == hefit_pkg::OP_DIV_C) begin
            div_num = $signed({{(NUM_W-CORE_W){c_core[CORE_W-1]}}, c_core}) <<< FRAC_BITS;
            div_den = {32'b0, h2_reg};
        end else if (cmd.op == hefit_pkg::OP_DIV_D) begin
            div_num = $signed({{(NUM_W-CORE_W){d_core[CORE_W-1]}}, d_core})
                      <<< (2 * FRAC_BITS);
            div_den = h3_reg;
        end else begin
            div_num = $signed({{(NUM_W-65){tan_dz[32]}}, tan_dz, 32'b0});
            div_den = {64'b0, tan_ds};
        end
    end

    hefit_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (mul_start),
        .a      (mul_a),
        .b      (h_reg),
        .done   (mul_done),
        .prod   (mul_prod)
    );

    hefit_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .done   (div_done),
        .quo    (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_reg <= s_data;
        end
        unique case (cmd.op)
            hefit_pkg::OP_SET_PRIOR: begin
                prior_s_reg <= in_reg.station;
                prior_z_reg <= in_reg.elevation;
            end
            hefit_pkg::OP_SHIFT: begin
                older_s_reg   <= prior_s_reg;
                older_z_reg   <= prior_z_reg;
                older_tan_reg <= ta_reg;
                prior_s_reg   <= in_reg.station;
                prior_z_reg   <= in_reg.elevation;
            end
            hefit_pkg::OP_TAN: div_dest_reg <= cmd.tan_to_b ? DST_TB : DST_TA;
            hefit_pkg::OP_SEG_LOAD: begin
                s0_reg       <= seg_s0;
                z0_reg       <= seg_z0;
                h_reg        <= 32'(seg_s1 - seg_s0);
                dz_reg       <= {seg_z1[31], seg_z1} - {seg_z0[31], seg_z0};
                m0_reg       <= cmd.m0_older_tan ? older_tan_reg : ta_reg;
                m1_reg       <= cmd.m1_from_b ? tb_reg : ta_reg;
                seg_last_reg <= cmd.seg_last;
            end
            hefit_pkg::OP_MUL:   mul_dest_reg <= cmd.mul_sel;
            hefit_pkg::OP_DIV_C: div_dest_reg <= DST_C;
            hefit_pkg::OP_DIV_D: div_dest_reg <= DST_D;
            hefit_pkg::OP_EMIT: begin
                out_reg <= '0;
                unique case (cmd.kind)
                    hefit_pkg::EMIT_LONE: begin
                        out_reg.segment_start <= in_reg.station;
                        out_reg.coef_a        <= in_reg.elevation;
                        out_reg.last_segment  <= 1'b1;
                    end
                    hefit_pkg::EMIT_ERR: begin
                        out_reg.status       <= 1'b1;
                        out_reg.last_segment <= 1'b1;
                    end
                    hefit_pkg::EMIT_SEG: begin
                        out_reg.segment_start <= s0_reg;
                        out_reg.coef_a        <= z0_reg;
                        out_reg.coef_b        <= m0_reg;
                        out_reg.coef_c        <= c_reg;
                        out_reg.coef_d        <= d_reg;
                        out_reg.last_segment  <= seg_last_reg;
                    end
                    default: out_reg.status <= 1'b1;
                endcase
            end
            default: ;
        endcase

        if (mul_done) begin
            unique case (mul_dest_reg)
                hefit_pkg::MUL_MH:
                    p_reg <= $signed({{17{dz_reg[32]}}, dz_reg, 32'b0})
                             - $signed(mul_prod[P_W-1:0]);
                hefit_pkg::MUL_QH: qh_reg <= $signed(mul_prod[P_W-1:0]);
                hefit_pkg::MUL_H2: h2_reg <= mul_prod[63:0];
                hefit_pkg::MUL_H3: h3_reg <= mul_prod[95:0];
                default: ;
            endcase
        end
        if (div_done) begin
            unique case (div_dest_reg)
                DST_TA: ta_reg <= div_quo;
                DST_TB: tb_reg <= div_quo;
                DST_C:  c_reg  <= div_quo;
                DST_D:  d_reg  <= div_quo;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == hefit_pkg::OP_EMIT) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.mul_done  = mul_done;
    assign sts.div_done  = div_done;
    assign sts.too_close = step_s <= $signed({17'b0, min_spacing});
    assign sts.in_last   = in_reg.last_point;
    assign sts.out_free  = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

### design/hefit_ctrl.sv
// Sequencer: decides per point which tangents and segments to build.
`include "hermite_elevation_profile_fit_unit_macros.svh"

module hefit_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    output logic                s_ready,
    input  hefit_pkg::dp_sts_t  sts,
    output hefit_pkg::dp_cmd_t  cmd
);
    typedef enum logic [4:0] {
        ST_IDLE, ST_DECIDE, ST_TAN, ST_TAN_WAIT, ST_SEG,
        ST_MUL_MH, ST_MH_WAIT, ST_MUL_QH, ST_QH_WAIT,
        ST_MUL_H2, ST_H2_WAIT, ST_MUL_H3, ST_H3_WAIT,
        ST_DIV_C, ST_C_WAIT, ST_DIV_D, ST_D_WAIT,
        ST_EMIT, ST_SHIFT
    } ctrl_state_t;

    ctrl_state_t            state_reg, state_next;
    logic [1:0]             pts_reg, pts_next;
    logic                   skip_reg, skip_next;
    logic                   second_reg, second_next;
    hefit_pkg::emit_kind_t  kind_reg, kind_next;
    logic                   first_of_two;

    // first segment of a point that closes two intervals
    assign first_of_two = (pts_reg == 2'd2) && !second_reg;
    assign s_ready      = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        pts_next    = pts_reg;
        skip_next   = skip_reg;
        second_next = second_reg;
        kind_next   = kind_reg;
        cmd         = '0;
        cmd.op      = hefit_pkg::OP_NONE;
        cmd.kind    = kind_reg;
        cmd.mul_sel = hefit_pkg::MUL_MH;
        unique case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_DECIDE;
            ST_DECIDE: begin
                priority if (skip_reg) begin
                    if (sts.in_last) skip_next = 1'b0;
                    state_next = ST_IDLE;
                end else if (pts_reg == 2'd0) begin
                    if (sts.in_last) begin
                        kind_next  = hefit_pkg::EMIT_LONE;
                        state_next = ST_EMIT;
                    end else begin
                        cmd.op     = hefit_pkg::OP_SET_PRIOR;
                        pts_next   = 2'd1;
                        state_next = ST_IDLE;
                    end
                end else if (sts.too_close) begin
                    kind_next  = hefit_pkg::EMIT_ERR;
                    pts_next   = 2'd0;
                    skip_next  = !sts.in_last;
                    state_next = ST_EMIT;
                end else begin
                    second_next = 1'b0;
                    state_next  = ST_TAN;
                end
            end
            ST_TAN: begin
                cmd.op         = hefit_pkg::OP_TAN;
                cmd.pair_older = first_of_two;
                cmd.tan_to_b   = second_reg;
                state_next     = ST_TAN_WAIT;
            end
            ST_TAN_WAIT: begin
                if (sts.div_done) begin
                    if (pts_reg == 2'd1 && !sts.in_last) state_next = ST_SHIFT;
                    else                                 state_next = ST_SEG;
                end
            end
            ST_SEG: begin
                cmd.op           = hefit_pkg::OP_SEG_LOAD;
                cmd.pair_older   = first_of_two;
                cmd.m0_older_tan = first_of_two;
                cmd.m1_from_b    = second_reg;
                cmd.seg_last     = !first_of_two;
                kind_next        = hefit_pkg::EMIT_SEG;
                state_next       = ST_MUL_MH;
            end
            ST_MUL_MH: begin
                cmd.op      = hefit_pkg::OP_MUL;
                cmd.mul_sel = hefit_pkg::MUL_MH;
                state_next  = ST_MH_WAIT;
            end
            ST_MH_WAIT: if (sts.mul_done) state_next = ST_MUL_QH;
            ST_MUL_QH: begin
                cmd.op      = hefit_pkg::OP_MUL;
                cmd.mul_sel = hefit_pkg::MUL_QH;
                state_next  = ST_QH_WAIT;
            end
            ST_QH_WAIT: if (sts.mul_done) state_next = ST_MUL_H2;
            ST_MUL_H2: begin
                cmd.op      = hefit_pkg::OP_MUL;
                cmd.mul_sel = hefit_pkg::MUL_H2;
                state_next  = ST_H2_WAIT;
            end
            ST_H2_WAIT: if (sts.mul_done) state_next = ST_MUL_H3;
            ST_MUL_H3: begin
                cmd.op      = hefit_pkg::OP_MUL;
                cmd.mul_sel = hefit_pkg::MUL_H3;
                state_next  = ST_H3_WAIT;
            end
            ST_H3_WAIT: if (sts.mul_done) state_next = ST_DIV_C;
            ST_DIV_C: begin
                cmd.op     = hefit_pkg::OP_DIV_C;
                state_next = ST_C_WAIT;
            end
            ST_C_WAIT: if (sts.div_done) state_next = ST_DIV_D;
            ST_DIV_D: begin
                cmd.op     = hefit_pkg::OP_DIV_D;
                state_next = ST_D_WAIT;
            end
            ST_D_WAIT: if (sts.div_done) state_next = ST_EMIT;
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.op = hefit_pkg::OP_EMIT;
                    if (kind_reg != hefit_pkg::EMIT_SEG) begin
                        state_next = ST_IDLE;
                    end else if (first_of_two) begin
                        if (sts.in_last) begin
                            second_next = 1'b1;
                            state_next  = ST_TAN;
                        end else begin
                            state_next = ST_SHIFT;
                        end
                    end else begin
                        pts_next   = 2'd0;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SHIFT: begin
                cmd.op     = hefit_pkg::OP_SHIFT;
                pts_next   = 2'd2;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            pts_reg    <= 2'd0;
            skip_reg   <= 1'b0;
            second_reg <= 1'b0;
            kind_reg   <= hefit_pkg::EMIT_SEG;
        end else begin
            state_reg  <= state_next;
            pts_reg    <= pts_next;
            skip_reg   <= skip_next;
            second_reg <= second_next;
            kind_reg   <= kind_next;
        end
    end

    `HEFIT_ASSERT_NOW(a_emit_room, cmd.op == hefit_pkg::OP_EMIT, sts.out_free, "emit with full output")
    `HEFIT_ASSERT_NOW(a_skip_empty, skip_reg, pts_reg == 2'd0, "skipping with points held")
    `HEFIT_ASSERT_NOW(a_mul_done_wait, sts.mul_done, state_reg == ST_MH_WAIT || state_reg == ST_QH_WAIT || state_reg == ST_H2_WAIT || state_reg == ST_H3_WAIT, "product outside wait")
    `HEFIT_ASSERT_NOW(a_div_done_wait, sts.div_done, state_reg == ST_TAN_WAIT || state_reg == ST_C_WAIT || state_reg == ST_D_WAIT, "quotient outside wait")
    `HEFIT_ASSERT_NEXT(a_shift_two, cmd.op == hefit_pkg::OP_SHIFT, pts_reg == 2'd2, "shift without two points")

endmodule

### design/hermite_elevation_profile_fit_unit.sv
// Work per point: nothing computed for a point that only stores history or is dropped,
// one emit for a lone point or a spacing error, one tangent for the second point of a profile,
// one tangent and one segment for an interior point or a two-point close, and two tangents
// and two segments for a closing point after two or more.
// Throughput: one point at a time; set by the shared radix-2 divider (1 bit/cycle).
// Reset (aresetn low, sync): sequencer idle, history empty, min_spacing back to 1.
module hermite_elevation_profile_fit_unit #(
    parameter int FRAC_BITS = hefit_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // point requests
    input  logic                                s_valid,
    output logic                                s_ready,
    input  hefit_pkg::in_t                      s_data,
    // segment results
    output logic                                m_valid,
    input  logic                                m_ready,
    output hefit_pkg::out_t                     m_data,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hefit_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [hefit_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [hefit_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    logic [hefit_pkg::MIN_SP_W-1:0] min_spacing_reg;
    logic                           in_fire;
    logic                           reg_hit;
    hefit_pkg::dp_cmd_t             cmd;
    hefit_pkg::dp_sts_t             sts;

    // Only register 0 (min_spacing) exists; paddr[2] set lands outside the map.
    assign reg_hit = (paddr[2] == 1'b0);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? {{(hefit_pkg::APB_DATA_W-hefit_pkg::MIN_SP_W){1'b0}},
                                min_spacing_reg}
                             : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_spacing_reg <= hefit_pkg::MIN_SP_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            min_spacing_reg <= pwdata[hefit_pkg::MIN_SP_W-1:0];
        end
    end

    // A point request is taken only while the sequencer is idle; the result
    // register lets the next point start while a segment still waits downstream.
    assign in_fire = s_valid && s_ready;

    hefit_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .in_fire(in_fire),
        .s_ready(s_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    // Datapath: tangents m = round(dz*2^32/ds); per interval
    // c = round(2^F(3P-QH)/H^2), d = round(2^2F(QH-2P)/H^3), saturated to 48 bits.
    hefit_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .s_data     (s_data),
        .min_spacing(min_spacing_reg),
        .cmd        (cmd),
        .sts        (sts),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
